// ===== rtl/core/sck_pkg.sv =====
// ----------------------------------------------------------------------------
// sck_pkg: shared types and constants of the cubic spline kernel
// Fixed-point formats, pipeline geometry and the item handed from the
// front pipeline through the queue to the back pipeline.
// ----------------------------------------------------------------------------
package sck_pkg;

    localparam int FRAC_BITS  = 16;           // fraction bits of r, h and outputs
    localparam int DIV_STEP   = 2;            // quotient bits per divider stage
    localparam int Q_BITS     = 30;           // fraction bits of q
    localparam int Q_STG      = Q_BITS / DIV_STEP;
    localparam int SPS        = 64 / DIV_STEP; // step stages per scaling slot
    localparam int SLOT_LEN   = SPS + 1;       // load stage plus step stages
    localparam int NSLOT      = 4;             // at most d+1 divisions by h
    localparam int NDIV       = NSLOT * SLOT_LEN;
    localparam int VSHIFT     = 44 - FRAC_BITS;
    localparam int SHW        = 34;            // width of the shape terms
    localparam int NLANE      = 3;
    localparam int LANE_W     = 0;
    localparam int LANE_R     = 1;
    localparam int LANE_H     = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] DIM_ONE   = 2'd1;
    localparam logic [1:0] DIM_TWO   = 2'd2;
    localparam logic [1:0] DIM_THREE = 2'd3;
    localparam logic [1:0] DIM_RESET = DIM_TWO;

    // normalization constants, Q.30
    localparam logic [31:0] NORM_D1 = 32'd1431655765;
    localparam logic [31:0] NORM_D2 = 32'd1953043645;
    localparam logic [31:0] NORM_D3 = 32'd2734261102;

    typedef struct packed {
        logic        bad;
        logic        outside;
        logic [1:0]  dim;
        logic [31:0] h;
        logic        neg_r;
        logic        neg_h;
    } meta_t;

    typedef struct packed {
        meta_t          meta;
        logic [SHW-1:0] p;
        logic [SHW-1:0] pm;
        logic [SHW-1:0] g;
    } item_t;

endpackage

// ===== rtl/core/sck_front.sv =====
// ----------------------------------------------------------------------------
// sck_front: input stage, q = r/h divider and spline shape polynomials
// Accepts one transaction per cycle unless its output stalls, classifies it
// and forms P, |P'| and |d P + q P'| for the back pipeline.
// ----------------------------------------------------------------------------
module sck_front import sck_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_distance,
    input  logic [31:0] s_smoothing_length,
    input  logic [1:0]  dimension,
    output logic        out_valid,
    input  logic        out_ready,
    output item_t       out_item
);

    typedef struct packed {
        logic        bad;
        logic        outside;
        logic        outer;
        logic [1:0]  dim;
        logic [31:0] h;
    } fmeta_t;

    localparam logic [30:0] ONE30 = 31'(1) << Q_BITS;

    logic        f_en;

    logic        f0_vld_reg;
    logic [31:0] f0_r_reg;
    fmeta_t      f0_meta_reg;

    logic        qv_reg    [Q_STG+1];
    logic [31:0] qrem_reg  [Q_STG+1];
    logic [30:0] qq_reg    [Q_STG+1];
    fmeta_t      qmeta_reg [Q_STG+1];
    logic [31:0] qrem_next [Q_STG+1];
    logic [30:0] qq_next   [Q_STG+1];

    logic        p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg, out_vld_reg;
    fmeta_t      p1_meta_reg, p2_meta_reg, p3_meta_reg, p4_meta_reg;
    logic [30:0] p1_q_reg, p1_x_reg, p1_sq_reg;
    logic [30:0] p2_q_reg, p2_sq_reg, p2_cube_reg;
    logic [30:0] p3_q_reg;
    logic [SHW-1:0] p3_p_reg, p3_pm_reg;
    logic [SHW-1:0] p4_p_reg, p4_pm_reg, p4_qpm_reg;
    item_t       out_item_reg;

    logic [30:0] p1_x_next, p1_sq_next, p2_cube_next;
    logic [SHW-1:0] p3_p_next, p3_pm_next, p4_qpm_next;
    item_t       out_item_next;

    function automatic logic [62:0] q_step(logic [31:0] rem, logic [30:0] q,
                                           logic [31:0] h);
        logic [32:0] t;
        logic [31:0] rm;
        logic [30:0] qv;
        rm = rem;
        qv = q;
        for (int i = 0; i < DIV_STEP; i++) begin
            t = {rm, 1'b0};
            if (t >= {1'b0, h}) begin
                t  = t - {1'b0, h};
                qv = {qv[29:0], 1'b1};
            end else begin
                qv = {qv[29:0], 1'b0};
            end
            rm = t[31:0];
        end
        return {rm, qv};
    endfunction

    assign f_en      = !out_vld_reg || out_ready;
    assign s_ready   = f_en;
    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

    // q divider: leading bit from r >= h, then DIV_STEP quotient bits per stage
    always_comb begin
        logic ge;
        ge = f0_r_reg >= f0_meta_reg.h;
        qrem_next[0] = ge ? f0_r_reg - f0_meta_reg.h : f0_r_reg;
        qq_next[0]   = {30'd0, ge};
        for (int j = 1; j <= Q_STG; j++) begin
            {qrem_next[j], qq_next[j]} = q_step(qrem_reg[j-1], qq_reg[j-1],
                                                qmeta_reg[j-1].h);
        end
    end

    // shape polynomials
    always_comb begin
        logic [61:0] sq_prod, cube_prod;
        logic [64:0] qpm_prod;
        logic signed [36:0] sq_s, cube_s, q_s, p_s, pm_s, g_s;
        logic [35:0] dp;
        p1_x_next    = qmeta_reg[Q_STG].outer ? ONE30 - qq_reg[Q_STG] : qq_reg[Q_STG];
        sq_prod      = 62'(p1_x_next) * 62'(p1_x_next);
        p1_sq_next   = 31'(sq_prod >> Q_BITS);
        cube_prod    = 62'(p1_sq_reg) * 62'(p1_x_reg);
        p2_cube_next = 31'(cube_prod >> Q_BITS);

        sq_s   = $signed({6'd0, p2_sq_reg});
        cube_s = $signed({6'd0, p2_cube_reg});
        q_s    = $signed({6'd0, p2_q_reg});
        if (p2_meta_reg.outer) begin
            p_s  = 37'sd2 * cube_s;
            pm_s = 37'sd6 * sq_s;
        end else begin
            p_s  = $signed({6'd0, ONE30}) - 37'sd6 * sq_s + 37'sd6 * cube_s;
            pm_s = 37'sd12 * q_s - 37'sd18 * sq_s;
        end
        p3_p_next  = p_s[36]  ? '0 : SHW'(p_s);
        p3_pm_next = pm_s[36] ? '0 : SHW'(pm_s);

        qpm_prod    = 65'(p3_q_reg) * 65'(p3_pm_reg);
        p4_qpm_next = SHW'(qpm_prod >> Q_BITS);

        dp  = 36'(p4_meta_reg.dim) * 36'(p4_p_reg);
        g_s = $signed({1'b0, dp}) - $signed({3'd0, p4_qpm_reg});
        out_item_next.meta.bad     = p4_meta_reg.bad;
        out_item_next.meta.outside = p4_meta_reg.outside;
        out_item_next.meta.dim     = p4_meta_reg.dim;
        out_item_next.meta.h       = p4_meta_reg.h;
        out_item_next.meta.neg_r   = p4_pm_reg != '0;
        out_item_next.meta.neg_h   = !g_s[36] && (g_s != '0);
        out_item_next.p            = p4_p_reg;
        out_item_next.pm           = p4_pm_reg;
        out_item_next.g            = g_s[36] ? SHW'(-g_s) : SHW'(g_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_vld_reg  <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int j = 0; j <= Q_STG; j++) begin
                qv_reg[j] <= 1'b0;
            end
        end else if (f_en) begin
            f0_vld_reg <= s_valid;
            qv_reg[0]  <= f0_vld_reg;
            for (int j = 1; j <= Q_STG; j++) begin
                qv_reg[j] <= qv_reg[j-1];
            end
            p1_vld_reg  <= qv_reg[Q_STG];
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            p4_vld_reg  <= p3_vld_reg;
            out_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_en) begin
            f0_r_reg            <= s_distance;
            f0_meta_reg.h       <= s_smoothing_length;
            f0_meta_reg.bad     <= s_smoothing_length == '0;
            f0_meta_reg.outside <= s_distance > s_smoothing_length;
            f0_meta_reg.outer   <= {s_distance, 1'b0} > {1'b0, s_smoothing_length};
            f0_meta_reg.dim     <= (dimension == 2'd0) ? DIM_ONE : dimension;

            qrem_reg[0]  <= qrem_next[0];
            qq_reg[0]    <= qq_next[0];
            qmeta_reg[0] <= f0_meta_reg;
            for (int j = 1; j <= Q_STG; j++) begin
                qrem_reg[j]  <= qrem_next[j];
                qq_reg[j]    <= qq_next[j];
                qmeta_reg[j] <= qmeta_reg[j-1];
            end

            p1_meta_reg <= qmeta_reg[Q_STG];
            p1_q_reg    <= qq_reg[Q_STG];
            p1_x_reg    <= p1_x_next;
            p1_sq_reg   <= p1_sq_next;

            p2_meta_reg <= p1_meta_reg;
            p2_q_reg    <= p1_q_reg;
            p2_sq_reg   <= p1_sq_reg;
            p2_cube_reg <= p2_cube_next;

            p3_meta_reg <= p2_meta_reg;
            p3_q_reg    <= p2_q_reg;
            p3_p_reg    <= p3_p_next;
            p3_pm_reg   <= p3_pm_next;

            p4_meta_reg <= p3_meta_reg;
            p4_p_reg    <= p3_p_reg;
            p4_pm_reg   <= p3_pm_reg;
            p4_qpm_reg  <= p4_qpm_next;

            out_item_reg <= out_item_next;
        end
    end

endmodule

// ===== rtl/core/sck_fifo.sv =====
// ----------------------------------------------------------------------------
// sck_fifo: short queue between the front and back pipelines
// Holds shape items so that either side can stall on its own.
// ----------------------------------------------------------------------------
module sck_fifo import sck_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               push, pop;

    assign in_ready  = count_reg != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/sck_back.sv =====
// ----------------------------------------------------------------------------
// sck_back: normalization, division by h and output rounding
// Three lanes (W, dW/dr, dW/dh) scale C times the shape term and divide it
// d or d+1 times by h in a pipelined long divider, then round and clip.
// ----------------------------------------------------------------------------
module sck_back import sck_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_weight,
    output logic [47:0] m_grad_r,
    output logic [47:0] m_grad_h,
    output logic        m_saturated,
    output logic        m_bad_length
);

    typedef struct packed {
        logic [63:0] sr;
        logic [31:0] rem;
        logic        ovf;
    } lane_t;

    typedef struct packed {
        logic        sat;
        logic [47:0] val;
    } emit_t;

    logic        b_en;

    logic        mul_vld_reg;
    meta_t       mul_meta_reg;
    logic [65:0] mul_prod_reg  [NLANE];
    logic [65:0] mul_prod_next [NLANE];

    logic        dvld_reg   [NDIV];
    meta_t       dmeta_reg  [NDIV];
    lane_t       lane_reg   [NDIV][NLANE];
    lane_t       lane_next  [NDIV][NLANE];

    logic        m_valid_reg;
    logic [47:0] m_weight_reg, m_grad_r_reg, m_grad_h_reg;
    logic [47:0] m_weight_next, m_grad_r_next, m_grad_h_next;
    logic        m_saturated_reg, m_bad_length_reg;
    logic        m_saturated_next, m_bad_length_next;

    function automatic logic [31:0] norm_const(logic [1:0] dim);
        case (dim)
            DIM_TWO:   return NORM_D2;
            DIM_THREE: return NORM_D3;
            default:   return NORM_D1;
        endcase
    endfunction

    // slot is active while it is below the lane's division count
    function automatic logic slot_act(int slot, logic [1:0] dim, int lane);
        logic [2:0] n;
        n = {1'b0, dim} + ((lane != LANE_W) ? 3'd1 : 3'd0);
        return 3'(slot) < n;
    endfunction

    function automatic lane_t div_load(logic [63:0] v, logic [31:0] h, logic act);
        lane_t a;
        logic [FRAC_BITS-1:0] hi;
        hi = v[63 -: FRAC_BITS];
        if (act) begin
            a.sr  = v << FRAC_BITS;
            a.rem = 32'(hi);
            a.ovf = 32'(hi) >= h;
        end else begin
            a.sr  = v;
            a.rem = '0;
            a.ovf = 1'b0;
        end
        return a;
    endfunction

    function automatic lane_t div_step(lane_t a, logic [31:0] h);
        lane_t b;
        logic [32:0] t;
        b = a;
        for (int i = 0; i < DIV_STEP; i++) begin
            t    = {b.rem, b.sr[63]};
            b.sr = {b.sr[62:0], 1'b0};
            if (t >= {1'b0, h}) begin
                t       = t - {1'b0, h};
                b.sr[0] = 1'b1;
            end
            b.rem = t[31:0];
        end
        return b;
    endfunction

    function automatic logic [63:0] div_result(lane_t a, logic act);
        return (act && a.ovf) ? '1 : a.sr;
    endfunction

    // round half up in magnitude, clip, apply sign
    function automatic emit_t emit(logic [63:0] mag, logic neg);
        emit_t e;
        logic [48:0] o, lim;
        o   = {1'b0, mag[63:16]} + 49'(mag[15]);
        lim = neg ? (49'(1) << 47) : (49'(1) << 47) - 49'(1);
        e.sat = o > lim;
        if (e.sat) begin
            o = lim;
        end
        e.val = neg ? 48'(0) - o[47:0] : o[47:0];
        return e;
    endfunction

    assign b_en         = !m_valid_reg || m_ready;
    assign in_ready     = b_en;
    assign m_valid      = m_valid_reg;
    assign m_weight     = m_weight_reg;
    assign m_grad_r     = m_grad_r_reg;
    assign m_grad_h     = m_grad_h_reg;
    assign m_saturated  = m_saturated_reg;
    assign m_bad_length = m_bad_length_reg;

    always_comb begin
        logic [31:0] c;
        c = norm_const(in_item.meta.dim);
        mul_prod_next[LANE_W] = 66'(c) * 66'(in_item.p);
        mul_prod_next[LANE_R] = 66'(c) * 66'(in_item.pm);
        mul_prod_next[LANE_H] = 66'(c) * 66'(in_item.g);
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            lane_next[0][l] = div_load(64'(mul_prod_reg[l] >> VSHIFT), mul_meta_reg.h,
                                       slot_act(0, mul_meta_reg.dim, l));
        end
        for (int j = 1; j < NDIV; j++) begin
            for (int l = 0; l < NLANE; l++) begin
                if (j % SLOT_LEN == 0) begin
                    lane_next[j][l] = div_load(
                        div_result(lane_reg[j-1][l],
                                   slot_act(j / SLOT_LEN - 1, dmeta_reg[j-1].dim, l)),
                        dmeta_reg[j-1].h,
                        slot_act(j / SLOT_LEN, dmeta_reg[j-1].dim, l));
                end else if (slot_act(j / SLOT_LEN, dmeta_reg[j-1].dim, l)) begin
                    lane_next[j][l] = div_step(lane_reg[j-1][l], dmeta_reg[j-1].h);
                end else begin
                    lane_next[j][l] = lane_reg[j-1][l];
                end
            end
        end
    end

    always_comb begin
        meta_t mt;
        emit_t ew, er, eh;
        mt = dmeta_reg[NDIV-1];
        ew = emit(div_result(lane_reg[NDIV-1][LANE_W],
                             slot_act(NSLOT-1, mt.dim, LANE_W)), 1'b0);
        er = emit(div_result(lane_reg[NDIV-1][LANE_R],
                             slot_act(NSLOT-1, mt.dim, LANE_R)), mt.neg_r);
        eh = emit(div_result(lane_reg[NDIV-1][LANE_H],
                             slot_act(NSLOT-1, mt.dim, LANE_H)), mt.neg_h);
        if (mt.bad || mt.outside) begin
            m_weight_next    = '0;
            m_grad_r_next    = '0;
            m_grad_h_next    = '0;
            m_saturated_next = 1'b0;
        end else begin
            m_weight_next    = ew.val;
            m_grad_r_next    = er.val;
            m_grad_h_next    = eh.val;
            m_saturated_next = ew.sat || er.sat || eh.sat;
        end
        m_bad_length_next = mt.bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < NDIV; j++) begin
                dvld_reg[j] <= 1'b0;
            end
        end else if (b_en) begin
            mul_vld_reg <= in_valid;
            dvld_reg[0] <= mul_vld_reg;
            for (int j = 1; j < NDIV; j++) begin
                dvld_reg[j] <= dvld_reg[j-1];
            end
            m_valid_reg <= dvld_reg[NDIV-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (b_en) begin
            mul_meta_reg <= in_item.meta;
            for (int l = 0; l < NLANE; l++) begin
                mul_prod_reg[l] <= mul_prod_next[l];
            end
            dmeta_reg[0] <= mul_meta_reg;
            for (int j = 1; j < NDIV; j++) begin
                dmeta_reg[j] <= dmeta_reg[j-1];
            end
            for (int j = 0; j < NDIV; j++) begin
                for (int l = 0; l < NLANE; l++) begin
                    lane_reg[j][l] <= lane_next[j][l];
                end
            end
            m_weight_reg     <= m_weight_next;
            m_grad_r_reg     <= m_grad_r_next;
            m_grad_h_reg     <= m_grad_h_next;
            m_saturated_reg  <= m_saturated_next;
            m_bad_length_reg <= m_bad_length_next;
        end
    end

endmodule

// ===== rtl/core/sph_cubic_spline_kernel.sv =====
// ----------------------------------------------------------------------------
// sph_cubic_spline_kernel: cubic spline smoothing kernel with gradients
// Top level: dimension register, front pipeline, queue, back pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes a distance r and smoothing length h (unsigned,
//   FRAC_BITS fraction bits) per transaction; the m_ channel returns one
//   transaction with W, dW/dr, dW/dh (signed, 48 bits), a saturated flag and
//   a bad_length flag (h of zero, values zero).
//   cfg_wr_en/cfg_wr_data write the dimension (1, 2 or 3; 0 acts as 1) and
//   must only be used while no transaction is in flight.
//   Throughput: one transaction per cycle while neither side stalls. The
//   front holds the q divider at 2 bits per stage and the polynomial
//   multipliers; the queue sits between front and back; the back holds up to
//   four chained 64-bit long divisions by h at 2 quotient bits per stage.
//   Reset (aresetn low, synchronous) empties all pipelines and sets the
//   dimension to 2. When m_ready is low the back pipeline holds, the queue
//   fills, and then s_ready drops; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module sph_cubic_spline_kernel import sck_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_distance,
    input  logic [31:0] s_smoothing_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_weight,
    output logic [47:0] m_grad_r,
    output logic [47:0] m_grad_h,
    output logic        m_saturated,
    output logic        m_bad_length
);

    logic [1:0] dim_reg;
    logic       fr_valid, fr_ready, bk_valid, bk_ready;
    item_t      fr_item, bk_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= DIM_RESET;
        end else if (cfg_wr_en) begin
            dim_reg <= cfg_wr_data;
        end
    end

    sck_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_distance         (s_distance),
        .s_smoothing_length (s_smoothing_length),
        .dimension          (dim_reg),
        .out_valid          (fr_valid),
        .out_ready          (fr_ready),
        .out_item           (fr_item)
    );

    sck_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_item  (bk_item)
    );

    sck_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (bk_valid),
        .in_ready     (bk_ready),
        .in_item      (bk_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_weight     (m_weight),
        .m_grad_r     (m_grad_r),
        .m_grad_h     (m_grad_h),
        .m_saturated  (m_saturated),
        .m_bad_length (m_bad_length)
    );

    // a zero smoothing length gives all-zero values and no clipping
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_length |->
            m_weight == '0 && m_grad_r == '0 && m_grad_h == '0 && !m_saturated)
        else $error("bad_length transaction with nonzero values");

    a_weight_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_weight[47])
        else $error("negative kernel weight");

    a_grad_r_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_grad_r[47] || m_grad_r == '0)
        else $error("positive radial gradient");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// ===== sim/sph_cubic_spline_kernel_test.sv =====
// ----------------------------------------------------------------------------
// sph_cubic_spline_kernel_test: self-checking bench for the cubic spline kernel
// Streams distance / smoothing length pairs under random back-pressure in
// several dimension settings, predicts W, dW/dr and dW/dh with the flags in
// a scoreboard and compares every result transaction in order.
// ----------------------------------------------------------------------------
module sph_cubic_spline_kernel_test;
    import sck_pkg::*;

    localparam logic [1:0] DIM_NONE = 2'd0;   // acts as dimension one
    localparam longint     ONE_Q30  = 64'sd1 << 30;

    typedef struct packed {
        logic [47:0] weight;
        logic [47:0] grad_r;
        logic [47:0] grad_h;
        logic        saturated;
        logic        bad_length;
    } kernel_result_t;

    class kernel_scoreboard;
        kernel_result_t pending[$];
        logic [1:0]     dim;
        int             mismatches;
        logic           sat_acc;

        function new();
            dim = DIM_RESET;
            mismatches = 0;
        endfunction

        // floor(a*b/div), clipped to 2^64-1
        function logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] div);
            logic [127:0] quo;
            quo = ({64'd0, a} * {64'd0, b}) / {64'd0, div};
            return (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
        endfunction

        function logic [63:0] scaled(logic [63:0] c, logic [63:0] shape,
                                     logic [31:0] h, int n);
            logic [63:0] v;
            v = mul_div(c, shape, 64'd1 << VSHIFT);
            for (int i = 0; i < n; i++)
                v = mul_div(v, 64'd1 << FRAC_BITS, {32'd0, h});
            return v;
        endfunction

        function logic [47:0] round_out(logic [63:0] mag, logic neg);
            logic [63:0] o;
            logic [63:0] lim;
            o = (mag >> 16) + mag[15];
            lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 1);
            if (o > lim) begin
                o = lim;
                sat_acc = 1'b1;
            end
            return neg ? 48'(-o) : o[47:0];
        endfunction

        function void note(logic [31:0] r, logic [31:0] h);
            kernel_result_t e;
            longint q, q2, q3, df, d2, d3, p, pm, g;
            int d;
            logic [63:0] c;
            e = '{48'd0, 48'd0, 48'd0, 1'b0, 1'b0};
            sat_acc = 1'b0;
            d = (dim == DIM_NONE) ? 1 : int'(dim);
            if (h == 0) begin
                e.bad_length = 1'b1;
            end else if (r <= h) begin
                q = longint'(({32'd0, r} << 30) / {32'd0, h});
                if ({1'b0, r, 1'b0} <= {2'b0, h}) begin
                    q2 = (q * q) >> 30;
                    q3 = (q2 * q) >> 30;
                    p  = ONE_Q30 - 6 * q2 + 6 * q3;
                    pm = 12 * q - 18 * q2;
                end else begin
                    df = ONE_Q30 - q;
                    d2 = (df * df) >> 30;
                    d3 = (d2 * df) >> 30;
                    p  = 2 * d3;
                    pm = 6 * d2;
                end
                if (p < 0) p = 0;
                if (pm < 0) pm = 0;
                g = longint'(d) * p - ((q * pm) >> 30);
                case (d)
                    1:       c = NORM_D1;
                    2:       c = NORM_D2;
                    default: c = NORM_D3;
                endcase
                e.weight = round_out(scaled(c, p, h, d), 1'b0);
                e.grad_r = round_out(scaled(c, pm, h, d + 1), pm != 0);
                if (g >= 0)
                    e.grad_h = round_out(scaled(c, g, h, d + 1), g != 0);
                else
                    e.grad_h = round_out(scaled(c, -g, h, d + 1), 1'b0);
                e.saturated = sat_acc;
            end
            pending.push_back(e);
        endfunction

        function void check(kernel_result_t got);
            kernel_result_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: W=%h dWdr=%h dWdh=%h",
                             got.weight, got.grad_r, got.grad_h);
                return;
            end
            e = pending.pop_front();
            if (got != e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp W=%h dr=%h dh=%h sat=%b bad=%b",
                              " / got W=%h dr=%h dh=%h sat=%b bad=%b"},
                             e.weight, e.grad_r, e.grad_h, e.saturated, e.bad_length,
                             got.weight, got.grad_r, got.grad_h, got.saturated,
                             got.bad_length);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = DIM_RESET;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_distance = '0;
    logic [31:0] s_smoothing_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_weight, m_grad_r, m_grad_h;
    logic        m_saturated, m_bad_length;

    kernel_scoreboard sb = new();
    bit steady = 1'b0;       // no idling on either side while set
    bit hold_request = 1'b0;

    always #5 aclk = ~aclk;

    sph_cubic_spline_kernel i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_distance(s_distance), .s_smoothing_length(s_smoothing_length),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_weight(m_weight), .m_grad_r(m_grad_r), .m_grad_h(m_grad_h),
        .m_saturated(m_saturated), .m_bad_length(m_bad_length)
    );

    function automatic bit idle_now();
        return !steady && ($urandom_range(0, 99) < 33);
    endfunction

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_pair(logic [31:0] r, logic [31:0] h);
        while (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_distance <= r;
        s_smoothing_length <= h;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        sb.note(r, h);
    endtask

    task automatic send_random();
        logic [31:0] h, r;
        int mode;
        h = $urandom >> $urandom_range(0, 31);
        mode = $urandom_range(0, 99);
        if (mode < 70)
            r = $urandom_range(0, h);
        else if (mode < 80)
            r = (h >> 1) + $urandom_range(0, 4) - 2;
        else if (mode < 88)
            r = (h == 32'hFFFF_FFFF) ? h : $urandom_range(h + 1, 32'hFFFF_FFFF);
        else if (mode < 95)
            r = $urandom;
        else begin
            r = $urandom;
            h = 32'd0;
        end
        send_pair(r, h);
    endtask

    task automatic write_dimension(logic [1:0] value);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.dim = value;
    endtask

    // result side: decide m_ready at each edge, check what is taken at the next
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold_request && hold == 0) begin
                hold_request = 1'b0;
                hold = 600;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= aresetn && !idle_now();
            end
            @(negedge aclk);
            if (m_valid && m_ready)
                sb.check('{m_weight, m_grad_r, m_grad_h, m_saturated, m_bad_length});
        end
    end

    initial begin
        logic [1:0] dims[5];
        logic [31:0] dir_r[14];
        logic [31:0] dir_h[14];
        dims = '{DIM_RESET, DIM_ONE, DIM_THREE, DIM_NONE, DIM_TWO};
        // zero length, tiny h (saturation), q = 0, support edges, half boundary
        dir_r = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'h0001_0000,
                  32'h0001_0001, 32'h0000_8000, 32'h0000_8001, 32'hFFFF_FFFF,
                  32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd2};
        dir_h = '{32'd0, 32'd0, 32'd1, 32'd1, 32'h0001_0000, 32'h0001_0000,
                  32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0)
                write_dimension(dims[ph]);
            for (int i = 0; i < 14; i++)
                send_pair(dir_r[i], dir_h[i]);
            for (int i = 0; i < 370; i++) begin
                steady = (ph == 1 && i >= 50 && i < 250);
                if (ph == 2 && i == 100)
                    hold_request = 1'b1;
                send_random();
            end
            steady = 1'b0;
        end
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
